// ----- rtl/core/btc_pkg.sv -----
// Shared types, constants and helpers of the block transposition cipher.
`default_nettype none

package btc_pkg;

  // Largest block the store is built for (default of the MAX_BLOCK parameter)
  localparam int MAX_BLOCK_DEF = 8;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int SIZE_W = 4;
  localparam int PERM_W = 24;
  localparam int SLOT_W = 3;
  localparam int REG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERM_MAP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECRYPT    = 2'd2;

  // Register reset values
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 4'd8;
  localparam logic [PERM_W-1:0] PERM_MAP_RST   = 24'd16434824;
  localparam logic              DECRYPT_RST    = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0] block_size;
    logic [PERM_W-1:0] perm_map;
    logic              decrypt_mode;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // take the input transaction into the block store
    logic step;       // advance the slot scan
    logic push_last;  // move the held byte to the output, marked last
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic flush;       // the offered byte completes or ends a block
    logic found;       // current scan cycle has a byte to emit
    logic scan_end;    // current scan cycle finishes the last slot
    logic hold_valid;  // a byte is held back waiting for its last flag
    logic out_free;    // output register can take a byte this cycle
  } status_t;

  // Three-bit permutation field for block position pos
  function automatic logic [SLOT_W-1:0] perm_field(input logic [PERM_W-1:0] map,
                                                   input logic [SLOT_W-1:0] pos);
    return map[SLOT_W*pos +: SLOT_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/btc_regs.sv -----
// Configuration registers of the block transposition cipher.
`default_nettype none

module btc_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [btc_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [btc_pkg::PERM_W-1:0]      cfg_data,
  output btc_pkg::cfg_t                        cfg
);

  // Register writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size   <= btc_pkg::BLOCK_SIZE_RST;
      cfg.perm_map     <= btc_pkg::PERM_MAP_RST;
      cfg.decrypt_mode <= btc_pkg::DECRYPT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        btc_pkg::REG_BLOCK_SIZE: cfg.block_size   <= cfg_data[btc_pkg::SIZE_W-1:0];
        btc_pkg::REG_PERM_MAP:   cfg.perm_map     <= cfg_data;
        btc_pkg::REG_DECRYPT:    cfg.decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/btc_ctrl.sv -----
// Controller state machine: gather bytes, scan slots, release the last byte.
`default_nettype none

module btc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire btc_pkg::status_t status,
  output btc_pkg::cmd_t         cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.accept = item_valid;
        if (item_valid && status.flush) state_next = S_SCAN;
      end
      S_SCAN: begin
        // hold off while a new byte would displace the held one into a full output
        cmd.step = !(status.found && status.hold_valid && !status.out_free);
        if (cmd.step && status.scan_end) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.hold_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/btc_dp.sv -----
// Datapath: block store, fill count, slot scanner, hold and output registers.
`default_nettype none

module btc_dp #(
  parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire btc_pkg::cfg_t    cfg,
  input  wire btc_pkg::item_t   item,
  input  wire btc_pkg::cmd_t    cmd,
  output btc_pkg::status_t      status,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output btc_pkg::result_t      result
);

  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int CMP_W = (CNT_W > btc_pkg::SIZE_W) ? CNT_W : btc_pkg::SIZE_W;
  localparam int CAP   = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;

  logic [btc_pkg::BYTE_W-1:0] store [MAX_BLOCK];
  logic [MAX_BLOCK-1:0]       nz;          // entry holds a nonzero byte
  logic [CNT_W-1:0]           fill;
  logic [CNT_W-1:0]           fill_inc;
  logic                       wr_ok;
  logic                       short_blk;
  logic [CMP_W-1:0]           present_x;
  logic [btc_pkg::SIZE_W-1:0] eff_n;
  logic [btc_pkg::SIZE_W-1:0] present;
  logic [btc_pkg::SLOT_W-1:0] slot;
  logic [MAX_BLOCK-1:0]       done;        // positions already sent in this slot
  logic [MAX_BLOCK-1:0]       hit;
  logic [MAX_BLOCK-1:0]       mask;
  logic [MAX_BLOCK-1:0]       rest;
  logic [IDX_W-1:0]           pick;
  logic                       found;
  logic                       slot_adv;
  logic [btc_pkg::BYTE_W-1:0] hold_byte;
  logic                       hold_valid;
  logic                       out_free;

  // Effective block size: zero acts as one, clamp to the store size but at most 8
  always_comb begin
    if (cfg.block_size == '0)
      eff_n = btc_pkg::SIZE_W'(1);
    else if (cfg.block_size > btc_pkg::SIZE_W'(CAP))
      eff_n = btc_pkg::SIZE_W'(CAP);
    else
      eff_n = cfg.block_size;
  end

  // Fill count after the offered byte, and whether the block goes out
  assign wr_ok     = CMP_W'(fill) < CMP_W'(MAX_BLOCK);
  assign fill_inc  = wr_ok ? fill + CNT_W'(1) : fill;
  assign short_blk = CMP_W'(fill_inc) < CMP_W'(eff_n);
  assign present_x = short_blk ? CMP_W'(fill_inc) : CMP_W'(eff_n);

  // Candidates for the current slot
  always_comb begin
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (cfg.decrypt_mode)
        hit[j] = CMP_W'(j) == CMP_W'(btc_pkg::perm_field(cfg.perm_map, slot));
      else
        hit[j] = btc_pkg::perm_field(cfg.perm_map, btc_pkg::SLOT_W'(j)) == slot;
      mask[j] = (CMP_W'(j) < CMP_W'(present)) && nz[j] && !done[j] && hit[j];
    end
  end

  // Lowest candidate wins; the slot is finished when no other remains
  always_comb begin
    pick = '0;
    for (int j = MAX_BLOCK - 1; j >= 0; j--) begin
      if (mask[j]) pick = IDX_W'(j);
    end
  end

  assign found    = |mask;
  assign rest     = mask & (mask - MAX_BLOCK'(1));
  assign slot_adv = (rest == '0);
  assign out_free = !result_valid || result_ready;

  assign status.flush      = !short_blk || item.end_of_message;
  assign status.found      = found;
  assign status.scan_end   = slot_adv &&
                             (btc_pkg::SIZE_W'(slot) + btc_pkg::SIZE_W'(1) == eff_n);
  assign status.hold_valid = hold_valid;
  assign status.out_free   = out_free;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        fill <= status.flush ? '0 : fill_inc;
        if (status.flush) hold_valid <= 1'b0;
      end
      if (cmd.step && found) hold_valid <= 1'b1;
      if (cmd.push_last) hold_valid <= 1'b0;
      // output register: load a byte, else free it once taken
      if ((cmd.step && found && hold_valid) || cmd.push_last)
        result_valid <= 1'b1;
      else if (result_valid && result_ready)
        result_valid <= 1'b0;
    end
  end

  // Store, scan position and payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_ok) begin
      store[fill[IDX_W-1:0]] <= item.data_byte;
      nz[fill[IDX_W-1:0]]    <= item.data_byte != '0;
    end
    if (cmd.accept && status.flush) begin
      present <= present_x[btc_pkg::SIZE_W-1:0];
      slot    <= '0;
      done    <= '0;
    end
    if (cmd.step) begin
      if (found) begin
        hold_byte <= store[pick];
        if (hold_valid) begin
          result.out_byte    <= hold_byte;
          result.last_of_run <= 1'b0;
        end
      end
      if (slot_adv) begin
        slot <= slot + btc_pkg::SLOT_W'(1);
        done <= '0;
      end else begin
        done[pick] <= 1'b1;
      end
    end
    if (cmd.push_last) begin
      result.out_byte    <= hold_byte;
      result.last_of_run <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/block_transposition_cipher.sv -----
// Top level of the block transposition cipher.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   item     | item_valid/item_ready  | item   : data_byte, end_of_message
//   result   | result_valid/ready     | result : out_byte, last_of_run
//   cfg      | cfg_valid/cfg_ready    | cfg_index (0 size, 1 perm, 2 mode), cfg_data
//
// A byte that does not close a block is stored and the input stays open. A byte
// that closes a block (full, or end_of_message) is stored, then the slot scan
// runs over the block's slots, sending each slot's bytes in turn or passing an
// empty slot, with one slot compare per cycle while the result is not stalled;
// a drain state then releases the held last byte.
// rst is synchronous; it clears the fill count and restores register defaults.
// A stalled result holds the scan; the next item is taken while the block's
// last byte still waits in the output register.
`default_nettype none

module block_transposition_cipher #(
  parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire btc_pkg::item_t                item,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output btc_pkg::result_t                   result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [btc_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [btc_pkg::PERM_W-1:0]    cfg_data
);

  btc_pkg::cfg_t    cfg;
  btc_pkg::cmd_t    cmd;
  btc_pkg::status_t status;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  btc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  btc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  btc_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- rtl/core/btc_checker.sv -----
// Port-level assertions for the block transposition cipher, bound to the top.
`default_nettype none

module btc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_valid,
  input wire logic                          item_ready,
  input wire btc_pkg::item_t                item,
  input wire logic                          result_valid,
  input wire logic                          result_ready,
  input wire btc_pkg::result_t              result
);

  // A stalled result transaction keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Zero bytes are never sent
  a_no_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.out_byte != '0)
    else $error("zero byte on result");

  // End of message always starts a flush, so input closes next cycle
  a_eom_flush: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.end_of_message |=> !item_ready)
    else $error("input open right after end of message");

  // Results are loaded only while a block is being emitted
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared outside a flush");

endmodule

bind block_transposition_cipher btc_checker u_btc_checker (.*);

`default_nettype wire
